/* rtl/core/mphd_pkg.sv */
// ----------------------------------------------------------------------------
// mphd_pkg
// Types and constants shared by the multi-pin hold-time debouncer.
// ----------------------------------------------------------------------------
package mphd_pkg;

	localparam int PIN_W    = 5;
	localparam int HOLD_IN_W = 16;
	localparam int INIT_W   = 2;
	localparam int WORD_W   = 32;

	// request function codes
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_REG  = 1'b1;

	// initial level codes, anything else is unknown
	localparam logic [INIT_W-1:0] LEVEL_LOW  = 2'd0;
	localparam logic [INIT_W-1:0] LEVEL_HIGH = 2'd1;

	typedef struct packed {
		logic                 func;
		logic [PIN_W-1:0]     pin;
		logic [HOLD_IN_W-1:0] hold_ticks;
		logic [INIT_W-1:0]    initial_level;
		logic [WORD_W-1:0]    levels;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] event_mask;
		logic [WORD_W-1:0] stable_levels;
	} rsp_t;

	// per-lane strobes, already qualified by the request handshake
	typedef struct packed {
		logic tick_en;
		logic reg_en;
		logic now;
		logic prev_lvl;
	} lane_cmd_t;

	// what a lane reports for the request being taken
	typedef struct packed {
		logic event_hit;
		logic stable;
	} lane_stat_t;

endpackage

/* rtl/core/mphd_req_if.sv */
// ----------------------------------------------------------------------------
// mphd_req_if
// Request channel of the debouncer: valid, ready and one request.
// ----------------------------------------------------------------------------
interface mphd_req_if import mphd_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/mphd_rsp_if.sv */
// ----------------------------------------------------------------------------
// mphd_rsp_if
// Result channel of the debouncer: valid, ready and one result.
// ----------------------------------------------------------------------------
interface mphd_rsp_if import mphd_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/multi_pin_hold_time_debouncer_top.sv */
// ----------------------------------------------------------------------------
// multi_pin_hold_time_debouncer_top
// Hold-time debouncer for up to 32 pins, one lane per pin.
// ----------------------------------------------------------------------------
// Takes one request per clock: a tick carrying the sampled level of every pin,
// or a register request that enables one pin (or just updates its hold time).
// Every lane updates in the cycle the request is taken and each request gives
// exactly one result, which is registered into the output buffer.
// A two-entry output buffer lets a new request be taken while a result is
// still waiting, so the block runs at one request per cycle as long as the
// result side keeps up; ready drops only when both buffer entries are full.
// Hold times count ticks; a zero hold matures on the tick of the edge.
module multi_pin_hold_time_debouncer_top import mphd_pkg::*; #(
	parameter int NUM_PINS   = 32,
	parameter int HOLD_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	mphd_req_if.sink   req,
	mphd_rsp_if.source rsp
);

	// only the first 32 pins can ever be sampled or registered
	localparam int LANES = (NUM_PINS < WORD_W) ? NUM_PINS : WORD_W;

	logic                  accept;
	logic                  full;
	logic                  pin_ok;
	logic [HOLD_WIDTH-1:0] hold;
	logic [LANES-1:0]      prev_q;
	logic [LANES-1:0]      evt_vec;
	logic [LANES-1:0]      stable_vec;

	assign req.ready = !full;
	assign accept    = req.valid && req.ready;
	assign pin_ok    = (int'(req.data.pin) < NUM_PINS);
	assign hold      = HOLD_WIDTH'(req.data.hold_ticks);

	// previous sample tracks every pin, enabled or not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (accept && (req.data.func == FUNC_TICK)) begin
			prev_q <= req.data.levels[LANES-1:0];
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		lane_cmd_t  cmd;
		lane_stat_t stat;

		assign cmd.tick_en  = accept && (req.data.func == FUNC_TICK);
		assign cmd.reg_en   = accept && (req.data.func == FUNC_REG) && pin_ok
			&& (req.data.pin == PIN_W'(i));
		assign cmd.now      = req.data.levels[i];
		assign cmd.prev_lvl = prev_q[i];

		mphd_lane #(
			.HOLD_WIDTH (HOLD_WIDTH)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.hold       (hold),
			.init_level (req.data.initial_level),
			.stat       (stat)
		);

		assign evt_vec[i]    = stat.event_hit;
		assign stable_vec[i] = stat.stable;
	end

	mphd_merge #(
		.LANES (LANES)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.evt_vec    (evt_vec),
		.stable_vec (stable_vec),
		.full       (full),
		.rsp        (rsp)
	);

endmodule

/* rtl/core/mphd_lane.sv */
// ----------------------------------------------------------------------------
// mphd_lane
// One pin's debounce state: enable, hold time, stable level, pending value.
// ----------------------------------------------------------------------------
module mphd_lane import mphd_pkg::*; #(
	parameter int HOLD_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lane_cmd_t             cmd,
	input  logic [HOLD_WIDTH-1:0] hold,
	input  logic [INIT_W-1:0]     init_level,
	output lane_stat_t            stat
);

	localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = {HOLD_WIDTH{1'b1}};

	logic                  enabled_q, known_q, level_q, pflag_q, plvl_q;
	logic [HOLD_WIDTH-1:0] age_q, hold_q;
	logic                  enabled_n, known_n, level_n, pflag_n, plvl_n;
	logic [HOLD_WIDTH-1:0] age_n;
	logic                  evt;

	always_comb begin
		enabled_n = enabled_q;
		known_n   = known_q;
		level_n   = level_q;
		pflag_n   = pflag_q;
		plvl_n    = plvl_q;
		age_n     = age_q;
		evt       = 1'b0;
		if (cmd.reg_en) begin
			// re-registration only replaces the hold time
			if (!enabled_q) begin
				enabled_n = 1'b1;
				pflag_n   = 1'b0;
				plvl_n    = 1'b0;
				age_n     = '0;
				known_n   = (init_level == LEVEL_LOW) || (init_level == LEVEL_HIGH);
				level_n   = (init_level == LEVEL_HIGH);
			end
		end else if (cmd.tick_en && enabled_q) begin
			if (cmd.now != cmd.prev_lvl) begin
				pflag_n = 1'b1;
				plvl_n  = cmd.now;
				age_n   = '0;
			end else if (pflag_q && (age_q != HOLD_MAX)) begin
				age_n = age_q + 1'b1;
			end
			if (pflag_n && (age_n >= hold_q)) begin
				if (!known_q || (level_q != plvl_n)) begin
					level_n = plvl_n;
					known_n = 1'b1;
					evt     = 1'b1;
				end
				pflag_n = 1'b0;
				plvl_n  = 1'b0;
				age_n   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			known_q   <= 1'b0;
			level_q   <= 1'b0;
			pflag_q   <= 1'b0;
			plvl_q    <= 1'b0;
			age_q     <= '0;
		end else begin
			enabled_q <= enabled_n;
			known_q   <= known_n;
			level_q   <= level_n;
			pflag_q   <= pflag_n;
			plvl_q    <= plvl_n;
			age_q     <= age_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reg_en) begin
			hold_q <= hold;
		end
	end

	assign stat.event_hit = evt;
	assign stat.stable    = enabled_n & level_n;

	a_event_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		evt |-> (cmd.tick_en && enabled_q))
		else $error("lane event outside an enabled tick");

	a_idle_age_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!pflag_q |-> (age_q == '0))
		else $error("lane age nonzero with nothing pending");

	a_disabled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!enabled_q |-> (!pflag_q && !known_q))
		else $error("disabled lane holds debounce state");

endmodule

/* rtl/core/mphd_merge.sv */
// ----------------------------------------------------------------------------
// mphd_merge
// Gathers the lane bits into result words and holds them in a two-entry
// output buffer so requests keep flowing while a result waits.
// ----------------------------------------------------------------------------
module mphd_merge import mphd_pkg::*; #(
	parameter int LANES = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [LANES-1:0] evt_vec,
	input  logic [LANES-1:0] stable_vec,
	output logic             full,
	mphd_rsp_if.source       rsp
);

	logic [1:0] count_q;
	rsp_t       buf0_q, buf1_q;
	rsp_t       entry;
	logic       pop;
	logic       wr_slot0;

	assign entry.event_mask    = WORD_W'(evt_vec);
	assign entry.stable_levels = WORD_W'(stable_vec);

	assign pop      = rsp.valid && rsp.ready;
	assign full     = (count_q == 2'd2);
	assign wr_slot0 = (count_q == 2'd0) || ((count_q == 2'd1) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (count_q == 2'd2)) begin
			buf0_q <= buf1_q;
		end
		if (push) begin
			if (wr_slot0) begin
				buf0_q <= entry;
			end else begin
				buf1_q <= entry;
			end
		end
	end

	assign rsp.valid = (count_q != 2'd0);
	assign rsp.data  = buf0_q;

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != 2'd2))
		else $error("result pushed into a full buffer");

	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("buffer count did not follow a push");

endmodule
